// ----- src/crop_box_average_downscale_macros.svh -----
// Assertion macros shared by the checker of the crop box average downscaler.
`ifndef CROP_BOX_AVERAGE_DOWNSCALE_MACROS_SVH
`define CROP_BOX_AVERAGE_DOWNSCALE_MACROS_SVH

// Same-cycle implication, disabled while reset is active.
`define CBAD_ASSERT_NOW(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is active.
`define CBAD_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);

`endif

// ----- src/cbad_pkg.sv -----
// Shared constants and types of the crop box average downscaler.
package cbad_pkg;

    localparam int DEF_MAX_WIDTH  = 2048;
    localparam int DEF_MAX_FACTOR = 16;

    localparam int PIX_W      = 8;
    localparam int POS_W      = 11;
    localparam int SIZE_W     = 12;
    localparam int FAC_W      = 5;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LEFT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_TOP    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_WIDTH  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_HEIGHT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FACTOR_X      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_FACTOR_Y      = 3'd6;

    localparam logic [SIZE_W-1:0] RST_FRAME_WIDTH   = 12'd640;
    localparam logic [POS_W-1:0]  RST_WINDOW_LEFT   = 11'd0;
    localparam logic [POS_W-1:0]  RST_WINDOW_TOP    = 11'd0;
    localparam logic [SIZE_W-1:0] RST_WINDOW_WIDTH  = 12'd640;
    localparam logic [SIZE_W-1:0] RST_WINDOW_HEIGHT = 12'd480;
    localparam logic [FAC_W-1:0]  RST_FACTOR_X      = 5'd1;
    localparam logic [FAC_W-1:0]  RST_FACTOR_Y      = 5'd1;

    typedef struct packed {
        logic in_ready;
        logic eval;
        logic merge;
        logic div_w_start;
        logic div_h_start;
        logic latch_w;
        logic latch_h;
        logic setup_fin;
        logic div_avg_start;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic in_valid;
        logic dirty;
        logic complete;
        logic emit;
        logic div_busy;
        logic out_free;
    } sts_t;

endpackage

// ----- src/cbad_stream_if.sv -----
// Handshake channel interfaces for pixel input and averaged output.
interface cbad_in_if;
    logic                      valid;
    logic                      ready;
    logic [cbad_pkg::PIX_W-1:0] pixel_in;
    logic                      frame_start;

    modport source (output valid, output pixel_in, output frame_start, input ready);
    modport sink (input valid, input pixel_in, input frame_start, output ready);
endinterface

interface cbad_out_if;
    logic                      valid;
    logic                      ready;
    logic [cbad_pkg::PIX_W-1:0] pixel_out;
    logic                      frame_end;

    modport source (output valid, output pixel_out, output frame_end, input ready);
    modport sink (input valid, input pixel_out, input frame_end, output ready);
endinterface

// ----- src/cbad_div.sv -----
// Restoring divider that produces one quotient bit per cycle.
module cbad_div #(
    parameter int N = 16,
    parameter int D = 9
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [N-1:0] dividend,
    input  logic [D-1:0] divisor,
    output logic         busy,
    output logic [N-1:0] quotient
);

    localparam int CNT_W = $clog2(N + 1);

    logic [N-1:0]     q_reg, q_next;
    logic [D:0]       r_reg, r_next;
    logic [D-1:0]     d_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic [D:0]       shifted;
    logic             ge;

    always_comb
    begin
        shifted = {r_reg[D-1:0], q_reg[N-1]};
        ge      = shifted >= {1'b0, d_reg};
        r_next  = ge ? (shifted - {1'b0, d_reg}) : shifted;
        q_next  = {q_reg[N-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_W'(N);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg <= dividend;
            r_reg <= '0;
            d_reg <= divisor;
        end
        else if (busy_reg)
        begin
            q_reg <= q_next;
            r_reg <= r_next;
        end
    end

    assign busy     = busy_reg;
    assign quotient = q_reg;

endmodule

// ----- src/cbad_ctrl.sv -----
// Controller state machine that sequences setup, item evaluation and averaging.
module cbad_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  cbad_pkg::sts_t sts,
    output cbad_pkg::cmd_t cmd
);

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_SW    = 10'b0000000010,
        S_WW    = 10'b0000000100,
        S_SH    = 10'b0000001000,
        S_WH    = 10'b0000010000,
        S_MUL   = 10'b0000100000,
        S_EVAL  = 10'b0001000000,
        S_MERGE = 10'b0010000000,
        S_DIV   = 10'b0100000000,
        S_LOAD  = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (sts.dirty)
                begin
                    state_next = S_SW;
                end
                else
                begin
                    cmd.in_ready = 1'b1;
                    if (sts.in_valid)
                    begin
                        state_next = S_EVAL;
                    end
                end
            end
            S_SW:
            begin
                cmd.div_w_start = 1'b1;
                state_next      = S_WW;
            end
            S_WW:
            begin
                if (!sts.div_busy)
                begin
                    cmd.latch_w = 1'b1;
                    state_next  = S_SH;
                end
            end
            S_SH:
            begin
                cmd.div_h_start = 1'b1;
                state_next      = S_WH;
            end
            S_WH:
            begin
                if (!sts.div_busy)
                begin
                    cmd.latch_h = 1'b1;
                    state_next  = S_MUL;
                end
            end
            S_MUL:
            begin
                cmd.setup_fin = 1'b1;
                state_next    = S_IDLE;
            end
            S_EVAL:
            begin
                cmd.eval   = 1'b1;
                state_next = S_IDLE;
                if (sts.complete)
                begin
                    state_next = S_MERGE;
                end
            end
            S_MERGE:
            begin
                cmd.merge  = 1'b1;
                state_next = S_IDLE;
                if (sts.emit)
                begin
                    cmd.div_avg_start = 1'b1;
                    state_next        = S_DIV;
                end
            end
            S_DIV:
            begin
                if (!sts.div_busy)
                begin
                    state_next = S_LOAD;
                end
            end
            S_LOAD:
            begin
                if (sts.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- src/cbad_datapath.sv -----
// Datapath with configuration, position counters, column sum memory and averaging.
module cbad_datapath #(
    parameter int MAX_WIDTH  = cbad_pkg::DEF_MAX_WIDTH,
    parameter int MAX_FACTOR = cbad_pkg::DEF_MAX_FACTOR
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [cbad_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [cbad_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  cbad_pkg::cmd_t                     cmd,
    output cbad_pkg::sts_t                     sts,
    cbad_in_if.sink                            in_ch,
    cbad_out_if.source                         out_ch
);

    localparam int POS_W  = cbad_pkg::POS_W;
    localparam int SIZE_W = cbad_pkg::SIZE_W;
    localparam int FAC_W  = cbad_pkg::FAC_W;
    localparam int PIX_W  = cbad_pkg::PIX_W;
    localparam int IDX_W  = $clog2(MAX_WIDTH);
    localparam int COL_W  = (IDX_W > POS_W) ? IDX_W : POS_W;
    localparam int CIB_W  = $clog2(MAX_FACTOR);
    localparam int FX_W   = $clog2(MAX_FACTOR + 1);
    localparam int PROD_W = $clog2(MAX_FACTOR * MAX_FACTOR + 1);
    localparam int SUM_W  = $clog2(255 * MAX_FACTOR * MAX_FACTOR + 1);
    localparam int WW_W   = $clog2(MAX_WIDTH + 1);
    localparam int XE_W   = $clog2(2047 + MAX_WIDTH + 1);
    localparam int YE_W   = 13;
    localparam int DIV_A  = (SUM_W > SIZE_W) ? SUM_W : SIZE_W;
    localparam int DIV_N  = (DIV_A > WW_W) ? DIV_A : WW_W;
    localparam int CMP_W  = 16;

    logic [SIZE_W-1:0] frame_width_reg, window_width_reg, window_height_reg;
    logic [POS_W-1:0]  window_left_reg, window_top_reg;
    logic [FAC_W-1:0]  factor_x_reg, factor_y_reg;
    logic              dirty_reg;

    logic [WW_W-1:0]   out_w_reg;
    logic [SIZE_W-1:0] out_h_reg;
    logic [XE_W-1:0]   x_end_reg;
    logic [YE_W-1:0]   y_end_reg;
    logic [PROD_W-1:0] fxfy_reg;

    logic [POS_W-1:0]  sc_reg, sr_reg, oc_reg, or_reg;
    logic [POS_W-1:0]  sc_next, sr_next, oc_next, or_next;
    logic [CIB_W-1:0]  cib_reg, rib_reg, cib_next, rib_next;
    logic [SUM_W-1:0]  rs_reg, rs_next;

    logic [PIX_W-1:0]  pix_reg;
    logic              fs_reg;

    logic              emit_reg, ok_reg, rib_nz_reg, fend_reg;
    logic [IDX_W-1:0]  wr_idx_reg;
    logic [SUM_W-1:0]  hold_reg, rdata_reg;
    logic [SUM_W-1:0]  col_mem [MAX_WIDTH];

    logic              out_valid_reg, out_fend_reg;
    logic [PIX_W-1:0]  out_pix_reg;

    logic [FX_W-1:0]   fx, fy;
    logic [WW_W-1:0]   fw, ww;
    logic [POS_W-1:0]  sc, sr, oc, orw;
    logic [CIB_W-1:0]  cib, rib;
    logic [SUM_W-1:0]  rs, rs_pix, total;
    logic              row_used, used, cib_last, rib_last, row_end, ok, fend;
    logic [COL_W-1:0]  oc_ext;
    logic              accept;

    logic              div_start, div_busy;
    logic [DIV_N-1:0]  div_dividend, div_quotient;
    logic [PROD_W-1:0] div_divisor;

    logic [WW_W+FX_W-1:0]   xprod;
    logic [SIZE_W+FX_W-1:0] yprod;
    logic [2*FX_W-1:0]      fprod;

    // Clamped effective settings.
    always_comb
    begin
        if (factor_x_reg == '0)
            fx = FX_W'(1);
        else if (32'(factor_x_reg) > MAX_FACTOR)
            fx = FX_W'(MAX_FACTOR);
        else
            fx = FX_W'(factor_x_reg);
        if (factor_y_reg == '0)
            fy = FX_W'(1);
        else if (32'(factor_y_reg) > MAX_FACTOR)
            fy = FX_W'(MAX_FACTOR);
        else
            fy = FX_W'(factor_y_reg);
        if (frame_width_reg == '0)
            fw = WW_W'(1);
        else if (32'(frame_width_reg) > MAX_WIDTH)
            fw = WW_W'(MAX_WIDTH);
        else
            fw = WW_W'(frame_width_reg);
        if (32'(window_width_reg) > MAX_WIDTH)
            ww = WW_W'(MAX_WIDTH);
        else
            ww = WW_W'(window_width_reg);
    end

    assign xprod = {{FX_W{1'b0}}, out_w_reg} * {{WW_W{1'b0}}, fx};
    assign yprod = {{FX_W{1'b0}}, out_h_reg} * {{SIZE_W{1'b0}}, fy};
    assign fprod = {{FX_W{1'b0}}, fx} * {{FX_W{1'b0}}, fy};

    // Effective position with frame start applied.
    always_comb
    begin
        sc  = fs_reg ? '0 : sc_reg;
        sr  = fs_reg ? '0 : sr_reg;
        oc  = fs_reg ? '0 : oc_reg;
        orw = fs_reg ? '0 : or_reg;
        cib = fs_reg ? '0 : cib_reg;
        rib = fs_reg ? '0 : rib_reg;
        rs  = fs_reg ? '0 : rs_reg;

        row_used = (CMP_W'(sr) >= CMP_W'(window_top_reg)) && (CMP_W'(sr) < CMP_W'(y_end_reg));
        used     = row_used && (CMP_W'(sc) >= CMP_W'(window_left_reg))
                   && (CMP_W'(sc) < CMP_W'(x_end_reg));
        cib_last = (CMP_W'(cib) + CMP_W'(1)) >= CMP_W'(fx);
        rib_last = (CMP_W'(rib) + CMP_W'(1)) >= CMP_W'(fy);
        row_end  = (CMP_W'(sc) + CMP_W'(1)) >= CMP_W'(fw);
        ok       = CMP_W'(oc) < CMP_W'(MAX_WIDTH);
        fend     = ((CMP_W'(oc) + CMP_W'(1)) == CMP_W'(out_w_reg))
                   && ((CMP_W'(orw) + CMP_W'(1)) == CMP_W'(out_h_reg));
        oc_ext   = COL_W'(oc);

        rs_pix = rs;
        if (used)
        begin
            rs_pix = (cib == '0) ? SUM_W'(pix_reg) : (rs + SUM_W'(pix_reg));
        end

        sc_next  = sc;
        sr_next  = sr;
        oc_next  = oc;
        or_next  = orw;
        cib_next = cib;
        rib_next = rib;
        rs_next  = rs_pix;
        if (used)
        begin
            if (cib_last)
            begin
                cib_next = '0;
                oc_next  = oc + POS_W'(1);
            end
            else
            begin
                cib_next = cib + CIB_W'(1);
            end
        end
        if (row_end)
        begin
            sc_next = '0;
            if (row_used)
            begin
                cib_next = '0;
                oc_next  = '0;
                rs_next  = '0;
                if (rib_last)
                begin
                    rib_next = '0;
                    or_next  = orw + POS_W'(1);
                end
                else
                begin
                    rib_next = rib + CIB_W'(1);
                end
            end
            sr_next = sr + POS_W'(1);
        end
        else
        begin
            sc_next = sc + POS_W'(1);
        end
    end

    assign total  = hold_reg + ((rib_nz_reg && ok_reg) ? rdata_reg : '0);
    assign accept = in_ch.valid && cmd.in_ready;

    // Configuration registers and the dirty mark that triggers setup.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg   <= cbad_pkg::RST_FRAME_WIDTH;
            window_left_reg   <= cbad_pkg::RST_WINDOW_LEFT;
            window_top_reg    <= cbad_pkg::RST_WINDOW_TOP;
            window_width_reg  <= cbad_pkg::RST_WINDOW_WIDTH;
            window_height_reg <= cbad_pkg::RST_WINDOW_HEIGHT;
            factor_x_reg      <= cbad_pkg::RST_FACTOR_X;
            factor_y_reg      <= cbad_pkg::RST_FACTOR_Y;
            dirty_reg         <= 1'b1;
        end
        else
        begin
            if (cmd.div_w_start)
            begin
                dirty_reg <= 1'b0;
            end
            if (cfg_we)
            begin
                dirty_reg <= 1'b1;
                case (cfg_index)
                    cbad_pkg::REG_FRAME_WIDTH:   frame_width_reg   <= cfg_data;
                    cbad_pkg::REG_WINDOW_LEFT:   window_left_reg   <= cfg_data[POS_W-1:0];
                    cbad_pkg::REG_WINDOW_TOP:    window_top_reg    <= cfg_data[POS_W-1:0];
                    cbad_pkg::REG_WINDOW_WIDTH:  window_width_reg  <= cfg_data;
                    cbad_pkg::REG_WINDOW_HEIGHT: window_height_reg <= cfg_data;
                    cbad_pkg::REG_FACTOR_X:      factor_x_reg      <= cfg_data[FAC_W-1:0];
                    cbad_pkg::REG_FACTOR_Y:      factor_y_reg      <= cfg_data[FAC_W-1:0];
                    default:                     ;
                endcase
            end
        end
    end

    // Derived frame geometry.
    always_ff @(posedge clk)
    begin
        if (cmd.latch_w)
        begin
            out_w_reg <= div_quotient[WW_W-1:0];
        end
        if (cmd.latch_h)
        begin
            out_h_reg <= div_quotient[SIZE_W-1:0];
        end
        if (cmd.setup_fin)
        begin
            x_end_reg <= XE_W'(window_left_reg) + XE_W'(xprod);
            y_end_reg <= YE_W'(window_top_reg) + YE_W'(yprod);
            fxfy_reg  <= fprod[PROD_W-1:0];
        end
    end

    // Position state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sc_reg  <= '0;
            sr_reg  <= '0;
            oc_reg  <= '0;
            or_reg  <= '0;
            cib_reg <= '0;
            rib_reg <= '0;
            rs_reg  <= '0;
        end
        else if (cmd.eval)
        begin
            sc_reg  <= sc_next;
            sr_reg  <= sr_next;
            oc_reg  <= oc_next;
            or_reg  <= or_next;
            cib_reg <= cib_next;
            rib_reg <= rib_next;
            rs_reg  <= rs_next;
        end
    end

    // Item capture and per-block flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            emit_reg <= 1'b0;
        end
        else if (cmd.eval)
        begin
            emit_reg <= rib_last;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pix_reg <= in_ch.pixel_in;
            fs_reg  <= in_ch.frame_start;
        end
        if (cmd.eval)
        begin
            ok_reg     <= ok;
            rib_nz_reg <= rib != '0;
            fend_reg   <= fend;
            wr_idx_reg <= oc_ext[IDX_W-1:0];
            hold_reg   <= rs_pix;
        end
    end

    // Column sum line store.
    always_ff @(posedge clk)
    begin
        if (cmd.merge && !emit_reg && ok_reg)
        begin
            col_mem[wr_idx_reg] <= total;
        end
        if (cmd.eval)
        begin
            rdata_reg <= col_mem[oc_ext[IDX_W-1:0]];
        end
    end

    // Shared divider for geometry setup and block averages.
    always_comb
    begin
        div_start    = cmd.div_w_start || cmd.div_h_start || cmd.div_avg_start;
        div_dividend = DIV_N'(total);
        div_divisor  = fxfy_reg;
        if (cmd.div_w_start)
        begin
            div_dividend = DIV_N'(ww);
            div_divisor  = PROD_W'(fx);
        end
        else if (cmd.div_h_start)
        begin
            div_dividend = DIV_N'(window_height_reg);
            div_divisor  = PROD_W'(fy);
        end
    end

    cbad_div #(
        .N (DIV_N),
        .D (PROD_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .quotient (div_quotient)
    );

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_pix_reg  <= div_quotient[PIX_W-1:0];
            out_fend_reg <= fend_reg;
        end
    end

    assign in_ch.ready      = cmd.in_ready;
    assign out_ch.valid     = out_valid_reg;
    assign out_ch.pixel_out = out_pix_reg;
    assign out_ch.frame_end = out_fend_reg;

    assign sts.in_valid = in_ch.valid;
    assign sts.dirty    = dirty_reg;
    assign sts.complete = used && cib_last;
    assign sts.emit     = emit_reg;
    assign sts.div_busy = div_busy;
    assign sts.out_free = !out_valid_reg || out_ch.ready;

endmodule

// ----- src/crop_box_average_downscale.sv -----
// Top level of the crop box average downscaler for 8-bit grey pixels.
//
//   Channel   Direction  Payload                    Accepted when
//   in_ch     sink       pixel_in, frame_start      valid and ready high
//   out_ch    source     pixel_out, frame_end       valid and ready high
//   cfg       write      cfg_index, cfg_data        cfg_we high
//
// An item that completes no block is only evaluated, one that completes a block row
// also passes the merge step into the column sum store, and one that completes a block
// also waits for the shared divider and for a free output register.
// After reset and after any configuration write, the divider first recomputes
// the frame geometry, with input held off.
// A stalled result sits in the output register while the next item is taken.
module crop_box_average_downscale #(
    parameter int MAX_WIDTH  = cbad_pkg::DEF_MAX_WIDTH,
    parameter int MAX_FACTOR = cbad_pkg::DEF_MAX_FACTOR
) (
    input  logic                            clk,
    input  logic                            rst_n,
    cbad_in_if.sink                         in_ch,
    cbad_out_if.source                      out_ch,
    input  logic                            cfg_we,
    input  logic [cbad_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [cbad_pkg::CFG_DATA_W-1:0] cfg_data
);

    cbad_pkg::cmd_t cmd;
    cbad_pkg::sts_t sts;

    cbad_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .sts   (sts),
        .cmd   (cmd)
    );

    cbad_datapath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_FACTOR (MAX_FACTOR)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .sts       (sts),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

endmodule

// ----- src/cbad_checker.sv -----
// Port-level checker of the crop box average downscaler and its bind.
`include "crop_box_average_downscale_macros.svh"

module cbad_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            in_valid,
    input logic                            in_ready,
    input logic                            out_valid,
    input logic                            out_ready,
    input logic [cbad_pkg::PIX_W-1:0]      pixel_out,
    input logic                            frame_end,
    input logic                            cfg_we
);

    `CBAD_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(pixel_out) && $stable(frame_end), "Stalled output item changed")
    `CBAD_ASSERT_NEXT(a_one_item, clk, rst_n, in_valid && in_ready, !in_ready, "Input taken again while an item is in work")
    `CBAD_ASSERT_NEXT(a_cfg_setup, clk, rst_n, cfg_we, !in_ready, "Input taken before geometry setup after a write")

endmodule

bind crop_box_average_downscale cbad_checker u_cbad_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .pixel_out (out_ch.pixel_out),
    .frame_end (out_ch.frame_end),
    .cfg_we    (cfg_we)
);

// ----- tb/sv/crop_box_average_downscale_tb.sv -----
// Self-checking testbench for the crop box average downscaler.
module crop_box_average_downscale_tb;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [cbad_pkg::PIX_W-1:0] pixel_out;
        logic                       frame_end;
    } block_average_t;

    logic                            clk;
    logic                            rst_n;
    logic                            cfg_we;
    logic [cbad_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [cbad_pkg::CFG_DATA_W-1:0] cfg_data;

    cbad_in_if  in_ch ();
    cbad_out_if out_ch ();

    crop_box_average_downscale u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Shadow copy of the registers and the scaler position state.
    logic [cbad_pkg::SIZE_W-1:0] sh_frame_width;
    logic [cbad_pkg::POS_W-1:0]  sh_left;
    logic [cbad_pkg::POS_W-1:0]  sh_top;
    logic [cbad_pkg::SIZE_W-1:0] sh_win_width;
    logic [cbad_pkg::SIZE_W-1:0] sh_win_height;
    logic [cbad_pkg::FAC_W-1:0]  sh_fx;
    logic [cbad_pkg::FAC_W-1:0]  sh_fy;

    int unsigned col_sum_store [cbad_pkg::DEF_MAX_WIDTH];
    int unsigned src_col;
    int unsigned src_row;
    int unsigned blk_row;
    int unsigned blk_col;
    int unsigned out_col;
    int unsigned out_row;
    int unsigned row_sum;

    block_average_t expected_averages[$];
    int             fail_count;
    int             burst_left;
    int unsigned    stall_cycle;

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic int unsigned clamp_size(int unsigned v, int unsigned hi);
        if (v == 0)
            return 1;
        if (v > hi)
            return hi;
        return v;
    endfunction

    function automatic void predict_block_average(logic [cbad_pkg::PIX_W-1:0] pix, logic fs);
        int unsigned    fw;
        int unsigned    fx;
        int unsigned    fy;
        int unsigned    ww;
        int unsigned    out_w;
        int unsigned    out_h;
        int unsigned    x_end;
        int unsigned    y_end;
        int unsigned    total;
        bit             row_used;
        bit             in_window;
        bit             col_ok;
        block_average_t res;
        fw = clamp_size(sh_frame_width, cbad_pkg::DEF_MAX_WIDTH);
        fx = clamp_size(sh_fx, cbad_pkg::DEF_MAX_FACTOR);
        fy = clamp_size(sh_fy, cbad_pkg::DEF_MAX_FACTOR);
        ww = (sh_win_width > cbad_pkg::DEF_MAX_WIDTH) ? cbad_pkg::DEF_MAX_WIDTH : sh_win_width;
        out_w = ww / fx;
        out_h = sh_win_height / fy;
        x_end = sh_left + out_w * fx;
        y_end = sh_top + out_h * fy;
        if (fs)
        begin
            src_col = 0;
            src_row = 0;
            blk_row = 0;
            blk_col = 0;
            out_col = 0;
            out_row = 0;
            row_sum = 0;
        end
        row_used = src_row >= sh_top && src_row < y_end;
        in_window = row_used && src_col >= sh_left && src_col < x_end;
        if (in_window)
        begin
            row_sum = (blk_col == 0) ? pix : row_sum + pix;
            if (blk_col + 1 >= fx)
            begin
                col_ok = out_col < cbad_pkg::DEF_MAX_WIDTH;
                total = row_sum;
                if (blk_row != 0 && col_ok)
                    total += col_sum_store[out_col];
                if (blk_row + 1 >= fy)
                begin
                    res.pixel_out = cbad_pkg::PIX_W'(total / (fx * fy));
                    res.frame_end = (out_col + 1 == out_w) && (out_row + 1 == out_h);
                    expected_averages.push_back(res);
                end
                else if (col_ok)
                begin
                    col_sum_store[out_col] = total;
                end
                blk_col = 0;
                out_col = (out_col + 1) & 11'h7FF;
            end
            else
            begin
                blk_col++;
            end
        end
        if (src_col + 1 >= fw)
        begin
            src_col = 0;
            if (row_used)
            begin
                blk_col = 0;
                out_col = 0;
                row_sum = 0;
                if (blk_row + 1 >= fy)
                begin
                    blk_row = 0;
                    out_row = (out_row + 1) & 11'h7FF;
                end
                else
                begin
                    blk_row++;
                end
            end
            src_row = (src_row + 1) & 11'h7FF;
        end
        else
        begin
            src_col++;
        end
    endfunction

    task automatic send_pixel(logic [cbad_pkg::PIX_W-1:0] pix, logic fs);
        in_ch.valid       <= 1'b1;
        in_ch.pixel_in    <= pix;
        in_ch.frame_start <= fs;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        predict_block_average(pix, fs);
        if (burst_left == 0)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6))
                @(posedge clk);
            burst_left = $urandom_range(0, 20);
        end
        else
        begin
            burst_left--;
        end
    endtask

    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        while (expected_averages.size() != 0)
            @(posedge clk);
        repeat (60)
            @(posedge clk);
    endtask

    task automatic write_reg(logic [cbad_pkg::CFG_IDX_W-1:0] idx,
                             logic [cbad_pkg::CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            cbad_pkg::REG_FRAME_WIDTH:   sh_frame_width = data;
            cbad_pkg::REG_WINDOW_LEFT:   sh_left        = data[cbad_pkg::POS_W-1:0];
            cbad_pkg::REG_WINDOW_TOP:    sh_top         = data[cbad_pkg::POS_W-1:0];
            cbad_pkg::REG_WINDOW_WIDTH:  sh_win_width   = data;
            cbad_pkg::REG_WINDOW_HEIGHT: sh_win_height  = data;
            cbad_pkg::REG_FACTOR_X:      sh_fx          = data[cbad_pkg::FAC_W-1:0];
            cbad_pkg::REG_FACTOR_Y:      sh_fy          = data[cbad_pkg::FAC_W-1:0];
            default:                     ;
        endcase
    endtask

    task automatic set_geometry(int fw, int left, int top, int ww, int wh, int fx, int fy);
        wait_idle();
        write_reg(cbad_pkg::REG_FRAME_WIDTH, cbad_pkg::CFG_DATA_W'(fw));
        write_reg(cbad_pkg::REG_WINDOW_LEFT, cbad_pkg::CFG_DATA_W'(left));
        write_reg(cbad_pkg::REG_WINDOW_TOP, cbad_pkg::CFG_DATA_W'(top));
        write_reg(cbad_pkg::REG_WINDOW_WIDTH, cbad_pkg::CFG_DATA_W'(ww));
        write_reg(cbad_pkg::REG_WINDOW_HEIGHT, cbad_pkg::CFG_DATA_W'(wh));
        write_reg(cbad_pkg::REG_FACTOR_X, cbad_pkg::CFG_DATA_W'(fx));
        write_reg(cbad_pkg::REG_FACTOR_Y, cbad_pkg::CFG_DATA_W'(fy));
    endtask

    task automatic test_reset_defaults();
        send_pixel(8'd0, 1'b1);
        send_pixel(8'd255, 1'b0);
        send_pixel(8'd128, 1'b0);
    endtask

    task automatic test_small_crop();
        set_geometry(4, 1, 1, 2, 2, 2, 2);
        for (int i = 0; i < 16; i++)
            send_pixel((i == 5 || i == 6) ? 8'd255 : 8'($urandom_range(0, 255)), i == 0);
    endtask

    task automatic test_factor_extremes();
        set_geometry(3, 0, 0, 3, 2, 0, 0);
        for (int i = 0; i < 6; i++)
            send_pixel(8'($urandom_range(0, 255)), i == 0);
        set_geometry(16, 0, 0, 16, 16, 31, 16);
        for (int i = 0; i < 256; i++)
            send_pixel((i < 128) ? 8'd255 : 8'($urandom_range(0, 255)), i == 0);
    endtask

    task automatic test_register_extremes();
        set_geometry(0, 0, 0, 1, 4095, 1, 1);
        for (int i = 0; i < 8; i++)
            send_pixel(8'($urandom_range(0, 255)), i == 0);
        set_geometry(4095, 2047, 2047, 4095, 4095, 2, 2);
        for (int i = 0; i < 12; i++)
            send_pixel(8'($urandom_range(0, 255)), i == 0);
        set_geometry(8, 2, 0, 2, 4, 3, 5);
        for (int i = 0; i < 32; i++)
            send_pixel(8'($urandom_range(0, 255)), i == 0);
    endtask

    task automatic test_random_frames();
        int fw;
        int top;
        int wh;
        int count;
        int sent;
        sent = 0;
        while (sent < 120)
        begin
            fw  = $urandom_range(1, 16);
            top = $urandom_range(0, 3);
            wh  = $urandom_range(1, 6);
            set_geometry(fw, $urandom_range(0, fw - 1), top, $urandom_range(1, fw + 2), wh,
                         $urandom_range(0, 5), $urandom_range(0, 4));
            count = fw * (top + wh) + $urandom_range(0, fw);
            for (int i = 0; i < count; i++)
                send_pixel(8'($urandom_range(0, 255)),
                           i == 0 || $urandom_range(0, 59) == 0);
            sent += count;
        end
    endtask

    always @(posedge clk)
    begin
        stall_cycle <= stall_cycle + 1;
        case ((stall_cycle / 97) % 3)
            0:       out_ch.ready <= 1'b1;
            1:       out_ch.ready <= (stall_cycle % 4) == 0;
            default: out_ch.ready <= $urandom_range(0, 1);
        endcase
    end

    always @(posedge clk)
    begin
        block_average_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (expected_averages.size() == 0)
            begin
                $display("%0t: unexpected result pixel_out=%0d frame_end=%0d",
                         $time, out_ch.pixel_out, out_ch.frame_end);
                fail_count++;
            end
            else
            begin
                want = expected_averages.pop_front();
                if (out_ch.pixel_out !== want.pixel_out)
                begin
                    $display("%0t: pixel_out expected %0d actual %0d",
                             $time, want.pixel_out, out_ch.pixel_out);
                    fail_count++;
                end
                if (out_ch.frame_end !== want.frame_end)
                begin
                    $display("%0t: frame_end expected %0d actual %0d",
                             $time, want.frame_end, out_ch.frame_end);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin
        #5ms;
        $display("FAILURE");
        $finish;
    end

    initial
    begin
        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_index         = cbad_pkg::REG_FRAME_WIDTH;
        cfg_data          = '0;
        in_ch.valid       = 1'b0;
        in_ch.pixel_in    = '0;
        in_ch.frame_start = 1'b0;
        out_ch.ready      = 1'b0;
        stall_cycle       = 0;
        fail_count        = 0;
        burst_left        = 0;
        sh_frame_width    = cbad_pkg::RST_FRAME_WIDTH;
        sh_left           = cbad_pkg::RST_WINDOW_LEFT;
        sh_top            = cbad_pkg::RST_WINDOW_TOP;
        sh_win_width      = cbad_pkg::RST_WINDOW_WIDTH;
        sh_win_height     = cbad_pkg::RST_WINDOW_HEIGHT;
        sh_fx             = cbad_pkg::RST_FACTOR_X;
        sh_fy             = cbad_pkg::RST_FACTOR_Y;
        src_col = 0;
        src_row = 0;
        blk_row = 0;
        blk_col = 0;
        out_col = 0;
        out_row = 0;
        row_sum = 0;
        repeat (5)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_small_crop();
        test_factor_extremes();
        test_register_extremes();
        test_random_frames();
        in_ch.valid <= 1'b0;
        wait_idle();
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule
